@@ rtl/unique_append_set_table_core_assert.svh @@
// ----------------------------------------------------------------------------
// unique_append_set_table_core assertion macros
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_APPEND_SET_TABLE_CORE_ASSERT_SVH
`define UNIQUE_APPEND_SET_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define UAST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UAST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/uast_pkg.sv @@
// ----------------------------------------------------------------------------
// uast_pkg
// Shared constants and types of the append-only unique key table.
// ----------------------------------------------------------------------------
package uast_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam int ITEM_W = 32;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int WIDE_W = 64;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_TEST = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } t_state;

endpackage

@@ rtl/uast_ram.sv @@
// ----------------------------------------------------------------------------
// uast_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module uast_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/unique_append_set_table_core.sv @@
// ----------------------------------------------------------------------------
// unique_append_set_table_core
// Append-only table of distinct nonzero keys with add, test and read commands.
// ----------------------------------------------------------------------------
// A command transfer happens on a rising edge with start high and busy low;
// i_command, i_item_key and i_read_index are sampled there. busy stays high
// while the command is worked on. The result shows for one cycle with o_done
// high; the receiver cannot stall, so it must take it in that cycle.
// o_entry_count gives the count after the command.
// Path from transfer to o_done:
//   null key, read beyond the count, unused code: result registered at the transfer
//   read within the count: key RAM read, then ST_READ registers the result
//   add or test: ST_SCAN compares the stored keys in turn, up to the count
// The key scan reads one entry per cycle through the single read port of the
// key RAM and stops early on a match. A command can be taken again in the
// cycle o_done is high.
// Synchronous reset empties the table;
// RAM contents are kept but only entries below the count are ever read.
// ----------------------------------------------------------------------------
module unique_append_set_table_core #(
    parameter int CAPACITY = uast_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = uast_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [uast_pkg::ITEM_W-1:0] i_item_key,
    input  logic [uast_pkg::IDX_W-1:0]  i_read_index,
    output logic                        o_done,
    output logic                        o_result_flag,
    output logic [uast_pkg::ITEM_W-1:0] o_read_value,
    output logic [uast_pkg::CNT_W-1:0]  o_entry_count,
    output logic                        o_table_full
);

    `include "unique_append_set_table_core_assert.svh"

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int XW    = (CW > uast_pkg::IDX_W) ? CW : uast_pkg::IDX_W;
    localparam int WW    = uast_pkg::WIDE_W;
    localparam int CNTW  = uast_pkg::CNT_W;

    uast_pkg::t_state      r_state, n_state;
    uast_pkg::t_cmd        r_cmd, n_cmd;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [CW-1:0]         r_ptr, n_ptr;
    logic                  r_pend, n_pend;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_done, n_done;
    logic                  r_flag, n_flag;
    logic [uast_pkg::ITEM_W-1:0] r_value, n_value;
    logic                  r_full, n_full;

    logic [WW-1:0]         w_key64;
    logic [KEY_BITS-1:0]   w_key_in;
    logic [XW-1:0]         w_idx_x;
    logic                  w_idx_ok;
    logic                  w_re, w_we;
    logic [AW-1:0]         w_raddr, w_waddr;
    logic [KEY_BITS-1:0]   w_wdata, w_rdata;
    logic [WW-1:0]         w_rd64;
    logic                  w_hit;

    assign w_key64  = WW'(i_item_key);
    assign w_key_in = w_key64[KEY_BITS-1:0];
    assign w_idx_x  = XW'(i_read_index);
    assign w_idx_ok = w_idx_x < XW'(r_count);
    assign w_rd64   = WW'(w_rdata);
    assign w_hit    = r_pend && (w_rdata == r_key);

    uast_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(CAPACITY)
    ) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uast_pkg::ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_ptr   <= n_ptr;
        r_flag  <= n_flag;
        r_value <= n_value;
        r_full  <= n_full;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_ptr   = r_ptr;
        n_pend  = 1'b0;
        n_count = r_count;
        n_done  = 1'b0;
        n_flag  = r_flag;
        n_value = r_value;
        n_full  = r_full;
        w_re    = 1'b0;
        w_raddr = r_ptr[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = r_key;
        case (r_state)
            uast_pkg::ST_IDLE: begin
                if (start) begin
                    n_key = w_key_in;
                    n_ptr = '0;
                    n_cmd = uast_pkg::t_cmd'(i_command);
                    case (uast_pkg::t_cmd'(i_command))
                        uast_pkg::CMD_ADD, uast_pkg::CMD_TEST: begin
                            if (w_key_in == '0) begin
                                n_done  = 1'b1;
                                n_flag  = 1'b0;
                                n_value = '0;
                                n_full  = 1'b0;
                            end else begin
                                n_state = uast_pkg::ST_SCAN;
                            end
                        end
                        uast_pkg::CMD_READ: begin
                            if (w_idx_ok) begin
                                w_re    = 1'b1;
                                w_raddr = w_idx_x[AW-1:0];
                                n_state = uast_pkg::ST_READ;
                            end else begin
                                n_done  = 1'b1;
                                n_flag  = 1'b0;
                                n_value = '0;
                                n_full  = 1'b0;
                            end
                        end
                        default: begin
                            n_done  = 1'b1;
                            n_flag  = 1'b0;
                            n_value = '0;
                            n_full  = 1'b0;
                        end
                    endcase
                end
            end
            uast_pkg::ST_SCAN: begin
                if (w_hit || (r_ptr == r_count)) begin
                    // scan over: hit, or last compare failed / table empty
                    n_done  = 1'b1;
                    n_value = '0;
                    n_state = uast_pkg::ST_IDLE;
                    if (r_cmd == uast_pkg::CMD_TEST) begin
                        n_flag = w_hit;
                        n_full = 1'b0;
                    end else if (w_hit) begin
                        n_flag = 1'b0;
                        n_full = 1'b0;
                    end else if (r_count < CW'(CAPACITY)) begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        n_flag  = 1'b1;
                        n_full  = 1'b0;
                    end else begin
                        n_flag = 1'b0;
                        n_full = 1'b1;
                    end
                end else begin
                    w_re   = 1'b1;
                    n_ptr  = r_ptr + 1'b1;
                    n_pend = 1'b1;
                end
            end
            uast_pkg::ST_READ: begin
                n_done  = 1'b1;
                n_flag  = 1'b1;
                n_value = w_rd64[uast_pkg::ITEM_W-1:0];
                n_full  = 1'b0;
                n_state = uast_pkg::ST_IDLE;
            end
            default: begin
                n_state = uast_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != uast_pkg::ST_IDLE);
    assign o_done        = r_done;
    assign o_result_flag = r_flag;
    assign o_read_value  = r_value;
    assign o_entry_count = CNTW'(r_count);
    assign o_table_full  = r_full;

    `UAST_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_done, "transfer lost")
    `UAST_ASSERT_NOW(a_full_refused, o_done && o_table_full,
        (r_count == CW'(CAPACITY)) && !o_result_flag, "full flag with room")
    `UAST_ASSERT_NOW(a_value_flagged, o_done && (o_read_value != '0), o_result_flag, "value without flag")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for unique_append_set_table_core
// Drives add, test and read commands, plus the spare command code, through
// the start/busy handshake. A queue of pending commands feeds a clocked
// driver. Each command is run through a local model of the key table when
// its transfer happens. A clocked monitor checks every o_done result
// against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOTS      = uast_pkg::CAPACITY_DEF;
    localparam int          RAND_CMDS  = 1333;
    localparam int          WATCHDOG   = 2000;
    localparam logic [1:0]  CMD_SPARE  = 2'd3;

    typedef struct packed {
        logic [1:0]                  op;
        logic [uast_pkg::ITEM_W-1:0] key;
        logic [uast_pkg::IDX_W-1:0]  index;
        logic                        drain;
    } t_cmd_item;

    typedef struct packed {
        logic                        flag;
        logic [uast_pkg::ITEM_W-1:0] value;
        logic [uast_pkg::CNT_W-1:0]  count;
        logic                        full;
    } t_table_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start        = 1'b0;
    logic                          busy;
    logic [1:0]                    i_command    = '0;
    logic [uast_pkg::ITEM_W-1:0]   i_item_key   = '0;
    logic [uast_pkg::IDX_W-1:0]    i_read_index = '0;
    logic                          o_done;
    logic                          o_result_flag;
    logic [uast_pkg::ITEM_W-1:0]   o_read_value;
    logic [uast_pkg::CNT_W-1:0]    o_entry_count;
    logic                          o_table_full;

    t_cmd_item                     cmd_pending[$];
    t_table_result                 result_due[$];
    logic [uast_pkg::ITEM_W-1:0]   planned_keys[$];
    t_cmd_item                     cur_cmd;
    t_table_result                 want;

    logic [uast_pkg::ITEM_W-1:0]   model_keys[SLOTS];
    logic [uast_pkg::CNT_W-1:0]    model_count = '0;

    int                  n_sent      = 0;
    int                  n_done      = 0;
    int                  n_errors    = 0;
    int                  stall_cycles = 0;

    unique_append_set_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_item_key    (i_item_key),
        .i_read_index  (i_read_index),
        .o_done        (o_done),
        .o_result_flag (o_result_flag),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_table_full  (o_table_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_table_result apply_command(t_cmd_item c);
        t_table_result r;
        logic          hit;
        r   = '0;
        hit = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (i < model_count && model_keys[i] == c.key) begin
                hit = 1'b1;
            end
        end
        case (c.op)
            uast_pkg::CMD_ADD: begin
                if (c.key != '0 && !hit) begin
                    if (model_count < SLOTS) begin
                        model_keys[model_count] = c.key;
                        model_count = model_count + 1'b1;
                        r.flag = 1'b1;
                    end else begin
                        r.full = 1'b1;
                    end
                end
            end
            uast_pkg::CMD_TEST: begin
                r.flag = (c.key != '0) && hit;
            end
            uast_pkg::CMD_READ: begin
                if (c.index < model_count) begin
                    r.flag  = 1'b1;
                    r.value = model_keys[c.index];
                end
            end
            default: ;
        endcase
        r.count = model_count;
        return r;
    endfunction

    // keeps a list of the keys the table will hold, so random keys can hit it
    task automatic queue_cmd(logic [1:0] op, logic [uast_pkg::ITEM_W-1:0] key,
                             logic [uast_pkg::IDX_W-1:0] idx, logic drain);
        logic known;
        known = 1'b0;
        foreach (planned_keys[i]) begin
            if (planned_keys[i] == key) begin
                known = 1'b1;
            end
        end
        if (op == uast_pkg::CMD_ADD && key != '0 && !known &&
            planned_keys.size() < SLOTS) begin
            planned_keys.push_back(key);
        end
        cmd_pending.push_back('{op, key, idx, drain});
    endtask

    function automatic logic [uast_pkg::ITEM_W-1:0] pick_key(int fresh_pct, logic flip);
        logic [uast_pkg::ITEM_W-1:0] k;
        int                          r;
        r = $urandom_range(0, 99);
        if (r < fresh_pct || planned_keys.size() == 0) begin
            k = $urandom;
        end else if (r < fresh_pct + 8) begin
            k = '0;
        end else if (r < fresh_pct + 16) begin
            case ($urandom_range(0, 3))
                0:       k = 32'hFFFF_FFFF;
                1:       k = 32'h8000_0000;
                2:       k = 32'h7FFF_FFFF;
                default: k = 32'h0000_0001;
            endcase
        end else begin
            k = planned_keys[$urandom_range(0, planned_keys.size() - 1)];
            if (flip && $urandom_range(0, 3) == 0) begin
                k = k ^ (32'h1 << $urandom_range(0, uast_pkg::ITEM_W - 1));
            end
        end
        return k;
    endfunction

    // driver
    always @(posedge i_clk) begin
        int outstanding;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            outstanding = n_sent - n_done;
            if (start && !busy) begin
                result_due.push_back(apply_command(cur_cmd));
                n_sent <= n_sent + 1;
                outstanding = outstanding + 1;
            end
            if (start && busy) begin
                // hold until the transfer
            end else if (cmd_pending.size() == 0 ||
                         (cmd_pending[0].drain && outstanding != 0) ||
                         (!(n_sent >= 500 && n_sent < 800) &&
                          $urandom_range(0, 99) < 37)) begin
                start <= 1'b0;
            end else begin
                cur_cmd = cmd_pending.pop_front();
                start        <= 1'b1;
                i_command    <= cur_cmd.op;
                i_item_key   <= cur_cmd.key;
                i_read_index <= cur_cmd.index;
            end
        end
    end

    task automatic field_mismatch(string field, logic [uast_pkg::ITEM_W-1:0] exp_v,
                                  logic [uast_pkg::ITEM_W-1:0] act_v);
        n_errors++;
        $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) begin
            n_done <= n_done + 1;
            if (result_due.size() == 0) begin
                n_errors++;
                $display("%0t: result with none expected, flag %0h value %0h count %0d",
                         $time, o_result_flag, o_read_value, o_entry_count);
            end else begin
                want = result_due.pop_front();
                if (o_result_flag !== want.flag)
                    field_mismatch("result_flag", want.flag, o_result_flag);
                if (o_read_value !== want.value)
                    field_mismatch("read_value", want.value, o_read_value);
                if (o_entry_count !== want.count)
                    field_mismatch("entry_count", want.count, o_entry_count);
                if (o_table_full !== want.full)
                    field_mismatch("table_full", want.full, o_table_full);
            end
        end
    end

    // watchdog: cycles with neither a command transfer nor a result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done === 1'b1) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles >= WATCHDOG) begin
                    $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [1:0] op;
        int         r;
        i_rst_n = 1'b0;

        // empty table
        queue_cmd(uast_pkg::CMD_TEST,  32'h0000_0000, 4'd0,  1'b0);
        queue_cmd(uast_pkg::CMD_READ,  32'h0000_0000, 4'd0,  1'b0);
        queue_cmd(uast_pkg::CMD_READ,  32'hFFFF_FFFF, 4'd15, 1'b0);
        queue_cmd(CMD_SPARE,           32'hFFFF_FFFF, 4'd15, 1'b0);
        queue_cmd(uast_pkg::CMD_ADD,   32'h0000_0000, 4'd0,  1'b0);
        // first entries, duplicate
        queue_cmd(uast_pkg::CMD_ADD,   32'hFFFF_FFFF, 4'd0,  1'b0);
        queue_cmd(uast_pkg::CMD_ADD,   32'hFFFF_FFFF, 4'd15, 1'b0);
        queue_cmd(uast_pkg::CMD_ADD,   32'h0000_0001, 4'd0,  1'b0);
        queue_cmd(uast_pkg::CMD_ADD,   32'h8000_0000, 4'd0,  1'b0);
        queue_cmd(uast_pkg::CMD_TEST,  32'hFFFF_FFFF, 4'd0,  1'b0);
        queue_cmd(uast_pkg::CMD_TEST,  32'h7FFF_FFFF, 4'd0,  1'b0);
        queue_cmd(uast_pkg::CMD_TEST,  32'h0000_0000, 4'd0,  1'b0);
        queue_cmd(uast_pkg::CMD_READ,  32'h0000_0000, 4'd0,  1'b0);
        queue_cmd(uast_pkg::CMD_READ,  32'h0000_0000, 4'd2,  1'b0);
        queue_cmd(uast_pkg::CMD_READ,  32'h0000_0000, 4'd3,  1'b0);
        queue_cmd(uast_pkg::CMD_READ,  32'hFFFF_FFFF, 4'd15, 1'b0);
        queue_cmd(CMD_SPARE,           32'h0000_0000, 4'd0,  1'b0);

        // table fills slowly at first, then saturates
        for (int n = 0; n < RAND_CMDS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35)      op = uast_pkg::CMD_ADD;
            else if (r < 70) op = uast_pkg::CMD_TEST;
            else if (r < 95) op = uast_pkg::CMD_READ;
            else             op = CMD_SPARE;
            queue_cmd(op,
                      pick_key((op == uast_pkg::CMD_ADD && n < 800) ? 4 : 40,
                               op != uast_pkg::CMD_ADD),
                      uast_pkg::IDX_W'($urandom_range(0, 15)),
                      (n % 200) == 0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (cmd_pending.size() != 0 || start || n_sent != n_done);
        repeat (SLOTS + 4) @(negedge i_clk);

        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
